// File: hw/rtl/abb_pkg.sv
// Shared types, widths and helper functions for the arc bounding box block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package abb_pkg;

  localparam int COORD_BITS = 32;
  localparam int DW         = COORD_BITS + 1;       // coordinate difference
  localparam int PW         = 2 * DW;               // signed product
  localparam int SUMW       = 2 * COORD_BITS + 1;   // sum of two squares
  localparam int ROOTW      = COORD_BITS + 1;       // integer square root bits
  localparam int REMW       = 2 * COORD_BITS + 3;   // root remainder / trial
  localparam int RW         = COORD_BITS + 2;       // rounded radius
  localparam int EW         = COORD_BITS + 3;       // center +- radius
  localparam int QDEPTH     = 4;
  localparam int QPW        = $clog2(QDEPTH);

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;

  typedef enum logic [1:0] {
    PLANE_XY    = 2'd0,
    PLANE_YZ    = 2'd1,
    PLANE_XZ    = 2'd2,
    PLANE_OTHER = 2'd3
  } plane_t;

  // Classified arc, front to back through the queue.
  typedef struct packed {
    diff_t  sx;
    diff_t  sy;
    diff_t  ex;
    diff_t  ey;
    coord_t cf;
    coord_t cs;
    coord_t fmin;
    coord_t fmax;
    coord_t smin;
    coord_t smax;
    coord_t amin;
    coord_t amax;
    logic   arc_en;
    logic   cw;
    logic   multi;
  } item_t;

  // Box payload carried along the radius pipeline.
  typedef struct packed {
    coord_t     cf;
    coord_t     cs;
    coord_t     fmin;
    coord_t     fmax;
    coord_t     smin;
    coord_t     smax;
    coord_t     amin;
    coord_t     amax;
    logic [3:0] incl;
  } bnd_t;

  function automatic logic signed [2:0] sgn3(input logic neg, input logic nz);
    logic signed [2:0] s;
    s = neg ? -3'sd1 : (nz ? 3'sd1 : 3'sd0);
    return s;
  endfunction

  // Is cardinal direction k inside the swept arc (non-full case)?
  // Signs are of the unflipped vectors; he is the half of the end direction.
  function automatic logic card_in(input logic [1:0] k, input logic cw,
                                   input logic signed [2:0] gsx,
                                   input logic signed [2:0] gsy,
                                   input logic signed [2:0] gex,
                                   input logic signed [2:0] gey,
                                   input logic he);
    logic signed [2:0] ux;
    logic signed [2:0] uy;
    logic signed [2:0] sy2;
    logic signed [2:0] ey2;
    logic signed [3:0] c;
    logic signed [3:0] d;
    logic signed [3:0] x;
    logic              hu;
    logic              res;
    case (k)
      2'd0: begin ux = 3'sd1;  uy = 3'sd0;  end
      2'd1: begin ux = 3'sd0;  uy = 3'sd1;  end
      2'd2: begin ux = -3'sd1; uy = 3'sd0;  end
      default: begin ux = 3'sd0; uy = -3'sd1; end
    endcase
    if (cw) uy = -uy;
    sy2 = cw ? -gsy : gsy;
    ey2 = cw ? -gey : gey;
    c = 4'(uy * gsx) - 4'(ux * sy2);
    d = 4'(ux * gsx) + 4'(uy * sy2);
    if (c > 0)      hu = 1'b0;
    else if (c < 0) hu = 1'b1;
    else            hu = (d > 0) ? 1'b0 : 1'b1;
    x = 4'(ux * ey2) - 4'(uy * gex);
    if (hu != he) res = !hu && he;
    else          res = (x >= 0);
    return res;
  endfunction

  function automatic coord_t sat_coord(input logic signed [EW-1:0] v);
    coord_t r;
    if (v > EW'(CMAX))      r = CMAX;
    else if (v < EW'(CMIN)) r = CMIN;
    else                    r = v[COORD_BITS-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/abb_front.sv
// Front end: input register and arc classification.
// Depends on abb_pkg.
`default_nettype none

module abb_front
  import abb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] start_u,
  input  wire logic [COORD_BITS-1:0] start_v,
  input  wire logic [COORD_BITS-1:0] start_axis,
  input  wire logic [COORD_BITS-1:0] end_u,
  input  wire logic [COORD_BITS-1:0] end_v,
  input  wire logic [COORD_BITS-1:0] end_axis,
  input  wire logic [COORD_BITS-1:0] center_first,
  input  wire logic [COORD_BITS-1:0] center_second,
  input  wire logic [8:0]            turns,
  input  wire logic [1:0]            plane_kind,
  input  wire logic                  q_full,
  output logic                       push,
  output item_t                      push_item
);

  logic   f_valid;
  coord_t sf, ss, sa, ef, es, ea, cf, cs;
  logic signed [8:0] tr;
  plane_t pk;
  diff_t  ex_raw, ey_raw;

  assign in_stall = f_valid && q_full;
  assign push     = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      sf <= start_u;
      ss <= start_v;
      sa <= start_axis;
      ef <= end_u;
      es <= end_v;
      ea <= end_axis;
      cf <= center_first;
      cs <= center_second;
      tr <= turns;
      pk <= plane_t'(plane_kind);
    end
  end

  always_comb begin
    push_item.sx = {sf[COORD_BITS-1], sf} - {cf[COORD_BITS-1], cf};
    push_item.sy = {ss[COORD_BITS-1], ss} - {cs[COORD_BITS-1], cs};
    ex_raw       = {ef[COORD_BITS-1], ef} - {cf[COORD_BITS-1], cf};
    ey_raw       = {es[COORD_BITS-1], es} - {cs[COORD_BITS-1], cs};
    // End at the center: take the end direction as +first axis.
    push_item.ex = (ex_raw == '0 && ey_raw == '0) ? DW'(1) : ex_raw;
    push_item.ey = ey_raw;
    push_item.cf = cf;
    push_item.cs = cs;
    push_item.fmin = (sf < ef) ? sf : ef;
    push_item.fmax = (sf < ef) ? ef : sf;
    push_item.smin = (ss < es) ? ss : es;
    push_item.smax = (ss < es) ? es : ss;
    push_item.amin = (sa < ea) ? sa : ea;
    push_item.amax = (sa < ea) ? ea : sa;
    push_item.arc_en = (pk != PLANE_OTHER) &&
                       (push_item.sx != '0 || push_item.sy != '0);
    push_item.cw    = tr[8];
    push_item.multi = (tr >= 9'sd2) || (tr <= -9'sd2);
  end

endmodule

`default_nettype wire

// File: hw/rtl/abb_queue.sv
// Short register queue between the front end and the radius pipeline.
// Depends on abb_pkg.
`default_nettype none

module abb_queue
  import abb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output item_t      head
);

  item_t          mem [QDEPTH];
  logic [QPW-1:0] wptr, rptr;
  logic [QPW:0]   cnt;

  assign full  = (cnt == (QPW+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
    if (push) mem[wptr] <= push_item;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QPW+1)'(QDEPTH)) else $error("queue count above depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1) else $error("queue count lost a push");
  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> cnt == $past(cnt) - 1'b1) else $error("queue count lost a pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    cnt[QPW-1:0] == QPW'(wptr - rptr)) else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: hw/rtl/abb_back.sv
// Back end: products and signs, pipelined square root, rounding, cardinal
// points and the final min/max into the output register. Depends on abb_pkg.
`default_nettype none

module abb_back
  import abb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  input  item_t                      q_head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      first_min,
  output logic [COORD_BITS-1:0]      first_max,
  output logic [COORD_BITS-1:0]      second_min,
  output logic [COORD_BITS-1:0]      second_max,
  output logic [COORD_BITS-1:0]      axis_min,
  output logic [COORD_BITS-1:0]      axis_max
);

  logic en;
  assign en  = !out_valid || !out_stall;
  assign pop = en && !q_empty;

  // Stage A: six products.
  logic            a_valid;
  item_t           a_item;
  logic signed [PW-1:0] p_xx, p_yy, p_xe, p_ye, p_dx, p_dy;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= pop;
    if (en) begin
      a_item <= q_head;
      p_xx <= q_head.sx * q_head.sx;
      p_yy <= q_head.sy * q_head.sy;
      p_xe <= q_head.sx * q_head.ey;
      p_ye <= q_head.sy * q_head.ex;
      p_dx <= q_head.sx * q_head.ex;
      p_dy <= q_head.sy * q_head.ey;
    end
  end

  // Stage B: sum of squares, cross/dot signs, cardinal mask.
  logic signed [PW:0] cross_v, dot_v;
  logic               full_c, he;
  logic signed [2:0]  gsx, gsy, gex, gey;
  bnd_t               b_next;
  logic               b_valid;
  bnd_t               b_bnd;
  logic [SUMW-1:0]    b_sum;

  always_comb begin
    cross_v = {p_xe[PW-1], p_xe} - {p_ye[PW-1], p_ye};
    dot_v   = {p_dx[PW-1], p_dx} + {p_dy[PW-1], p_dy};
    full_c  = a_item.multi || (cross_v == '0 && dot_v > 0);
    // Clockwise mirrors the plane, which negates the cross product.
    if (cross_v == '0)             he = (dot_v > 0) ? 1'b0 : 1'b1;
    else if ((cross_v < 0) != a_item.cw) he = 1'b1;
    else                           he = 1'b0;
    gsx = sgn3(a_item.sx[DW-1], a_item.sx != '0);
    gsy = sgn3(a_item.sy[DW-1], a_item.sy != '0);
    gex = sgn3(a_item.ex[DW-1], a_item.ex != '0);
    gey = sgn3(a_item.ey[DW-1], a_item.ey != '0);
    b_next.cf   = a_item.cf;
    b_next.cs   = a_item.cs;
    b_next.fmin = a_item.fmin;
    b_next.fmax = a_item.fmax;
    b_next.smin = a_item.smin;
    b_next.smax = a_item.smax;
    b_next.amin = a_item.amin;
    b_next.amax = a_item.amax;
    for (int k = 0; k < 4; k++) begin
      b_next.incl[k] = a_item.arc_en &&
        (full_c || card_in(2'(k), a_item.cw, gsx, gsy, gex, gey, he));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
    if (en) begin
      b_bnd <= b_next;
      b_sum <= {1'b0, p_xx[2*COORD_BITS-1:0]} + {1'b0, p_yy[2*COORD_BITS-1:0]};
    end
  end

  // Square root: one result bit per stage, most significant first.
  logic             s_valid [ROOTW+1];
  bnd_t             s_bnd   [ROOTW+1];
  logic [REMW-1:0]  s_rem   [ROOTW+1];
  logic [ROOTW-1:0] s_root  [ROOTW+1];

  assign s_valid[0] = b_valid;
  assign s_bnd[0]   = b_bnd;
  assign s_rem[0]   = REMW'(b_sum);
  assign s_root[0]  = '0;

  for (genvar i = 0; i < ROOTW; i++) begin : g_sqrt
    localparam int BIT = ROOTW - 1 - i;
    logic [REMW-1:0] trial;
    assign trial = (REMW'(s_root[i]) << (BIT + 1)) | (REMW'(1) << (2 * BIT));
    always_ff @(posedge clk) begin
      if (rst) s_valid[i+1] <= 1'b0;
      else if (en) s_valid[i+1] <= s_valid[i];
      if (en) begin
        s_bnd[i+1] <= s_bnd[i];
        if (s_rem[i] >= trial) begin
          s_rem[i+1]  <= s_rem[i] - trial;
          s_root[i+1] <= s_root[i] | (ROOTW'(1) << BIT);
        end else begin
          s_rem[i+1]  <= s_rem[i];
          s_root[i+1] <= s_root[i];
        end
      end
    end
  end

  // Stage C: round to nearest.
  logic          c_valid;
  bnd_t          c_bnd;
  logic [RW-1:0] c_r;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= s_valid[ROOTW];
    if (en) begin
      c_bnd <= s_bnd[ROOTW];
      c_r   <= RW'(s_root[ROOTW]) +
               RW'(s_rem[ROOTW] > REMW'(s_root[ROOTW]));
    end
  end

  // Stage D: cardinal coordinates, saturated.
  logic   d_valid;
  bnd_t   d_bnd;
  coord_t px0, px2, py1, py3;
  logic signed [EW-1:0] cf_e, cs_e, r_e;

  always_comb begin
    cf_e = EW'(c_bnd.cf);
    cs_e = EW'(c_bnd.cs);
    r_e  = $signed(EW'(c_r));
  end

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (en) d_valid <= c_valid;
    if (en) begin
      d_bnd <= c_bnd;
      px0 <= sat_coord(cf_e + r_e);
      px2 <= sat_coord(cf_e - r_e);
      py1 <= sat_coord(cs_e + r_e);
      py3 <= sat_coord(cs_e - r_e);
    end
  end

  // Output stage: fold included points into the endpoint box.
  coord_t fmin_n, fmax_n, smin_n, smax_n;

  always_comb begin
    fmin_n = d_bnd.fmin;
    fmax_n = d_bnd.fmax;
    smin_n = d_bnd.smin;
    smax_n = d_bnd.smax;
    if (d_bnd.incl[0]) begin
      if (px0 < fmin_n) fmin_n = px0;
      if (px0 > fmax_n) fmax_n = px0;
    end
    if (d_bnd.incl[2]) begin
      if (px2 < fmin_n) fmin_n = px2;
      if (px2 > fmax_n) fmax_n = px2;
    end
    if (d_bnd.incl[1] || d_bnd.incl[3]) begin
      if (d_bnd.cf < fmin_n) fmin_n = d_bnd.cf;
      if (d_bnd.cf > fmax_n) fmax_n = d_bnd.cf;
    end
    if (d_bnd.incl[1]) begin
      if (py1 < smin_n) smin_n = py1;
      if (py1 > smax_n) smax_n = py1;
    end
    if (d_bnd.incl[3]) begin
      if (py3 < smin_n) smin_n = py3;
      if (py3 > smax_n) smax_n = py3;
    end
    if (d_bnd.incl[0] || d_bnd.incl[2]) begin
      if (d_bnd.cs < smin_n) smin_n = d_bnd.cs;
      if (d_bnd.cs > smax_n) smax_n = d_bnd.cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= d_valid;
    if (en) begin
      first_min  <= fmin_n;
      first_max  <= fmax_n;
      second_min <= smin_n;
      second_max <= smax_n;
      axis_min   <= d_bnd.amin;
      axis_max   <= d_bnd.amax;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(d_valid) && $stable(c_valid) && $stable(b_valid))
    else $error("pipeline moved while output stalled");
  a_pop_en: assert property (@(posedge clk) disable iff (rst)
    pop |-> en && !q_empty) else $error("pop without room");
  a_box: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(first_min) <= $signed(first_max)) &&
                  ($signed(second_min) <= $signed(second_max)))
    else $error("inverted box");

endmodule

`default_nettype wire

// File: hw/rtl/arc_bounding_box_core.sv
// Top level of the arc bounding box block: front end, queue and back end.
// Depends on abb_pkg, abb_front, abb_queue and abb_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one arc move per beat:
//   start, end and center in Q16.16, a signed turn count and the plane kind.
//   Output channel (out_valid / out_stall) returns one bounding box per beat
//   in the same order.
//   The arc lands in the input register at the edge that accepts it, then
//   passes through one queue entry, two product/sign stages, one stage per
//   radius bit in the square root (33), rounding, cardinal points and the
//   output register, which loads its box.
//   Throughput is one arc per cycle while out_stall is low; the square
//   root is a fully pipelined bit-per-stage unit, so nothing in the block
//   iterates. While out_stall is high with out_valid set, the back
//   pipeline holds; the front keeps taking beats until its four-entry queue
//   and its input register hold five arcs, then raises in_stall.
//   Reset clears all valid flags and the queue pointers and count; the data
//   registers are not reset, and the block needs no warm-up.
`default_nettype none

module arc_bounding_box_core
  import abb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] start_u,
  input  wire logic [COORD_BITS-1:0] start_v,
  input  wire logic [COORD_BITS-1:0] start_axis,
  input  wire logic [COORD_BITS-1:0] end_u,
  input  wire logic [COORD_BITS-1:0] end_v,
  input  wire logic [COORD_BITS-1:0] end_axis,
  input  wire logic [COORD_BITS-1:0] center_first,
  input  wire logic [COORD_BITS-1:0] center_second,
  input  wire logic [8:0]            turns,
  input  wire logic [1:0]            plane_kind,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      first_min,
  output logic [COORD_BITS-1:0]      first_max,
  output logic [COORD_BITS-1:0]      second_min,
  output logic [COORD_BITS-1:0]      second_max,
  output logic [COORD_BITS-1:0]      axis_min,
  output logic [COORD_BITS-1:0]      axis_max
);

  logic  push, pop, q_full, q_empty;
  item_t push_item, q_head;

  // Classify each arc and hand it to the queue.
  abb_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .start_u, .start_v, .start_axis,
    .end_u, .end_v, .end_axis,
    .center_first, .center_second, .turns, .plane_kind,
    .q_full, .push, .push_item
  );

  // Decouple the front from output backpressure.
  abb_queue u_queue (
    .clk, .rst, .push, .push_item, .pop,
    .full(q_full), .empty(q_empty), .head(q_head)
  );

  // Radius, cardinal tests and the final box.
  abb_back u_back (
    .clk, .rst, .q_empty, .q_head, .pop,
    .out_valid, .out_stall,
    .first_min, .first_max, .second_min, .second_max, .axis_min, .axis_max
  );

endmodule

`default_nettype wire

// File: bench/tb_arc_bounding_box_core.sv
// Self-checking bench for arc_bounding_box_core: directed and random arc moves,
// predicted boxes checked against the output channel in order.
// Depends on abb_pkg and the arc_bounding_box_core RTL.
`default_nettype none

class box_scoreboard;
  typedef struct {
    logic signed [31:0] fmin, fmax, smin, smax, amin, amax;
  } box_t;

  box_t pending[$];
  int   errors;
  int   checked;

  // Sign of a*b - c*d, computed exactly in wide signed arithmetic.
  static function int prod_cmp(longint a, longint b, longint c, longint d);
    logic signed [129:0] p, q;
    p = 130'(a) * 130'(b);
    q = 130'(c) * 130'(d);
    return (p > q) ? 1 : ((p < q) ? -1 : 0);
  endfunction

  static function int half(longint sx, longint sy, longint ux, longint uy);
    int c;
    c = prod_cmp(sx, uy, sy, ux);
    if (c > 0) return 0;
    if (c < 0) return 1;
    return (prod_cmp(sx, ux, -sy, uy) > 0) ? 0 : 1;
  endfunction

  // Counter-clockwise angle s->u no larger than angle s->w.
  static function bit angle_le(longint sx, longint sy, longint ux, longint uy,
                               longint wx, longint wy);
    int hu, hw;
    hu = half(sx, sy, ux, uy);
    hw = half(sx, sy, wx, wy);
    if (hu != hw) return hu < hw;
    return prod_cmp(ux, wy, uy, wx) >= 0;
  endfunction

  // Nearest-integer square root of dx^2 + dy^2.
  static function longint round_radius(longint dx, longint dy);
    logic [129:0] sum, cand;
    logic [63:0]  r;
    sum = 130'(dx) * 130'(dx) + 130'(dy) * 130'(dy);
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = 130'(r | (64'd1 << b));
      if (cand * cand <= sum) r = r | (64'd1 << b);
    end
    if (sum > 130'(r) * 130'(r) + 130'(r)) r = r + 1;
    return longint'(r);
  endfunction

  static function longint clamp(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void note_arc(longint sf, longint ss, longint sa, longint ef, longint es,
                         longint ea, longint cf, longint cs, int tr, int pk);
    box_t   b;
    longint fmin, fmax, smin, smax, sx, sy, ex, ey, r, px, py, my;
    longint cx[4], cy[4];
    bit     cw, full;
    cx = '{1, 0, -1, 0};
    cy = '{0, 1, 0, -1};
    fmin = sf < ef ? sf : ef; fmax = sf < ef ? ef : sf;
    smin = ss < es ? ss : es; smax = ss < es ? es : ss;
    sx = sf - cf; sy = ss - cs;
    if (pk != abb_pkg::PLANE_OTHER && (sx != 0 || sy != 0)) begin
      r = round_radius(sx, sy);
      ex = ef - cf; ey = es - cs;
      cw = tr < 0;
      if (ex == 0 && ey == 0) ex = 1;
      full = (tr >= 2 || tr <= -2) ||
             (prod_cmp(sx, ey, sy, ex) == 0 && prod_cmp(sx, ex, -sy, ey) > 0);
      if (cw) begin sy = -sy; ey = -ey; end
      for (int k = 0; k < 4; k++) begin
        my = cw ? -cy[k] : cy[k];
        if (full || angle_le(sx, sy, cx[k], my, ex, ey)) begin
          px = clamp(cf + r * cx[k]);
          py = clamp(cs + r * cy[k]);
          if (px < fmin) fmin = px;
          if (px > fmax) fmax = px;
          if (py < smin) smin = py;
          if (py > smax) smax = py;
        end
      end
    end
    b.fmin = 32'(fmin); b.fmax = 32'(fmax); b.smin = 32'(smin); b.smax = 32'(smax);
    b.amin = 32'(sa < ea ? sa : ea); b.amax = 32'(sa < ea ? ea : sa);
    pending = {pending, b};
  endfunction

  function void check_box(box_t got);
    box_t e;
    checked++;
    if (pending.size() == 0) begin
      $display("%0t: box with no arc waiting: %p", $time, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.fmin != e.fmin) report("first_min", e.fmin, got.fmin);
    if (got.fmax != e.fmax) report("first_max", e.fmax, got.fmax);
    if (got.smin != e.smin) report("second_min", e.smin, got.smin);
    if (got.smax != e.smax) report("second_max", e.smax, got.smax);
    if (got.amin != e.amin) report("axis_min", e.amin, got.amin);
    if (got.amax != e.amax) report("axis_max", e.amax, got.amax);
  endfunction

  function void report(string name, logic signed [31:0] e, logic signed [31:0] g);
    $display("%0t: %s expected %0d got %0d", $time, name, e, g);
    errors++;
  endfunction
endclass

module tb_arc_bounding_box_core;
  import abb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     start_u = '0, start_v = '0, start_axis = '0;
  coord_t     end_u = '0, end_v = '0, end_axis = '0;
  coord_t     center_first = '0, center_second = '0;
  logic [8:0] turns = '0;
  logic [1:0] plane_kind = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  coord_t     first_min, first_max, second_min, second_max, axis_min, axis_max;

  box_scoreboard boxes = new();
  bit            feeding_done = 0;
  bit            hold_off_req = 0;   // sender asks the receiver for a long stall

  arc_bounding_box_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one arc, hold it until accepted, and note it for prediction.
  task automatic send_arc(coord_t sf, coord_t ss, coord_t sa, coord_t ef, coord_t es,
                          coord_t ea, coord_t cf, coord_t cs, logic [8:0] tr,
                          logic [1:0] pk, int gap);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_u <= sf; start_v <= ss; start_axis <= sa;
    end_u <= ef; end_v <= es; end_axis <= ea;
    center_first <= cf; center_second <= cs;
    turns <= tr; plane_kind <= pk;
    do @(posedge clk); while (in_stall);
    boxes.note_arc(sf, ss, sa, ef, es, ea, cf, cs, $signed(tr), pk);
  endtask

  // Hold off until every noted arc has come back.
  task automatic drain();
    while (boxes.pending.size() != 0) @(posedge clk);
  endtask

  // Draw one random arc. Most are small circles so cardinal points matter;
  // a few use full-range or extreme coordinates.
  task automatic send_random(int gap);
    coord_t     cf, cs, sf, ss, ef, es;
    logic [8:0] tr;
    int         mode, rad;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      rad = (mode < 3) ? $urandom_range(0, 16) : $urandom_range(0, 32'h0100_0000);
      cf = $urandom; cs = $urandom;
      if ($urandom_range(0, 1)) begin cf = cf >>> 2; cs = cs >>> 2; end
      sf = cf + $signed($urandom_range(0, 2 * rad)) - rad;
      ss = cs + $signed($urandom_range(0, 2 * rad)) - rad;
      // End on an axis through the centre now and then to hit boundaries.
      case ($urandom_range(0, 3))
        0: begin ef = cf + rad; es = cs; end
        1: begin ef = sf; es = ss; end
        default: begin
          ef = cf + $signed($urandom_range(0, 2 * rad)) - rad;
          es = cs + $signed($urandom_range(0, 2 * rad)) - rad;
        end
      endcase
    end else begin
      sf = $urandom; ss = $urandom; ef = $urandom; es = $urandom;
      cf = $urandom; cs = $urandom;
      if (mode == 9) begin cf = $urandom_range(0, 1) ? CMAX : CMIN; sf = -cf; end
    end
    case ($urandom_range(0, 5))
      0: tr = 9'd0;
      1: tr = 9'h1ff;
      2: tr = 9'($urandom);
      default: tr = 9'd1;
    endcase
    if (tr == 9'h100) tr = 9'h101;
    send_arc(sf, ss, $urandom, ef, es, $urandom, cf, cs, tr,
             2'($urandom_range(0, 3)), gap);
  endtask

  // Check every accepted box; stall at random, or long on request.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      boxes.check_box('{first_min, first_max, second_min, second_max, axis_min, axis_max});
  end

  initial begin : receiver
    int wait_cycles;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off_req = 0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (feeding_done || $urandom_range(0, 9) < 3) wait_cycles = 0;
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    coord_t     zero;
    logic [8:0] tr_ccw, tr_cw, tr_two;
    int         n_random, gap;
    zero = '0; tr_ccw = 9'd1; tr_cw = 9'h1ff; tr_two = 9'd2;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Arcs between axis points, CCW and CW, each main plane and the other plane.
    send_arc(100, 0, 5, 0, 100, -5, 0, 0, tr_ccw, PLANE_XY, 0);
    send_arc(100, 0, 5, 0, 100, -5, 0, 0, tr_cw, PLANE_YZ, 0);
    send_arc(100, 0, 5, 0, 100, -5, 0, 0, tr_ccw, PLANE_OTHER, 0);
    send_arc(100, 0, 5, 0, -100, 5, 0, 0, 9'd0, PLANE_XZ, 0);
    // Full circle by equal direction and by turn count, zero radius, end at centre.
    send_arc(7, 3, 0, 14, 6, 0, 0, 0, tr_ccw, PLANE_XY, 1);
    send_arc(7, 3, 0, -7, 3, 0, 0, 0, tr_two, PLANE_XY, 0);
    send_arc(7, 3, 0, -7, 3, 0, 0, 0, 9'h100 + 9'h1, PLANE_XY, 0);
    send_arc(50, 50, 1, 9, -9, 2, 50, 50, tr_ccw, PLANE_XY, 0);
    send_arc(30, 40, 1, 0, 0, 2, 0, 0, tr_cw, PLANE_XY, 0);
    // Extremes with saturation of centre plus or minus radius.
    send_arc(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, tr_ccw, PLANE_XY, 0);
    send_arc(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, 9'h0ff, PLANE_YZ, 0);
    send_arc(CMAX, CMAX, zero, CMIN, CMIN, zero, CMIN, CMIN, 9'h101, PLANE_XZ, 2);
    send_arc(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
             32'haaaa_aaaa, 32'h5555_5555, zero, zero, tr_cw, PLANE_XY, 0);
    // Non-integer radius, rounding: 1,1 gives 1.414 -> 1; 1,2 -> 2.236 -> 2.
    send_arc(1, 1, 0, -1, 1, 0, 0, 0, tr_ccw, PLANE_XY, 0);
    send_arc(1, 2, 0, 2, -1, 0, 0, 0, tr_cw, PLANE_XY, 0);

    // Pause until every expected box has come back.
    in_valid <= 1'b0;
    drain();
    repeat (45) @(posedge clk);

    n_random = 2000;
    for (int i = 0; i < n_random; i++) begin
      // Partway through, let the receiver hold off long while we keep pushing.
      if (i == 600) hold_off_req = 1;
      if (i == 1200) begin
        in_valid <= 1'b0;
        drain();
        @(posedge clk);
      end
      gap = ((i / 150) % 3 == 0) ? 0 : $urandom_range(0, 4);
      if (hold_off_req) gap = 0;
      send_random(gap);
    end
    in_valid <= 1'b0;
    feeding_done = 1;
    drain();
    repeat (50) @(posedge clk);
    $display("Checked %0d boxes: directed arcs, %0d random arcs in all planes,",
             boxes.checked, n_random);
    $display("full circles, clockwise sweeps, saturation and stall back-pressure.");
    if (boxes.errors == 0 && boxes.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire
